### hdl/gcab_pkg.sv
// gcab_pkg: shared types, codes and helpers for the glyph coverage alpha blend block
`default_nettype none
package gcab_pkg;

  localparam logic [1:0] REQ_BLEND = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_REGION_LEFT   = 2'd0;
  localparam logic [1:0] CFG_REGION_TOP    = 2'd1;
  localparam logic [1:0] CFG_REGION_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_REGION_HEIGHT = 2'd3;

  localparam int CFG_DATA_W = 12;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] image_left;
    logic [11:0] image_top;
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [7:0]  coverage;
    logic [31:0] packed_color;
  } req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       pixel_written;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_ADDR,
    ST_READ,
    ST_LOAD,
    ST_AN_EST,
    ST_AN_DIV,
    ST_NA_MUL,
    ST_NA_EST,
    ST_NA_DIV,
    ST_CH_MUL1,
    ST_CH_MUL2,
    ST_CH_EST,
    ST_CH_DIV,
    ST_CH_SUM,
    ST_DIVIDE,
    ST_WRITE,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // first guess of x / 255, low by at most one
  function automatic logic [16:0] div255_est(input logic [23:0] x);
    logic [24:0] s;
    s = 25'(x) + 25'(x[23:8]) + 25'(x[23:16]);
    return s[24:8];
  endfunction

  // one compare and add to correct the guess
  function automatic logic [16:0] div255_fix(input logic [23:0] x, input logic [16:0] q);
    logic [25:0] r;
    r = 26'(x) + 26'(q) - {1'b0, q, 8'b0};
    return (r >= 26'd255) ? q + 17'd1 : q;
  endfunction

endpackage
`default_nettype wire

### hdl/gcab_if.sv
// gcab_if: valid/ready channels for requests and results
`default_nettype none
interface gcab_req_if
  import gcab_pkg::*;
  ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gcab_rsp_if
  import gcab_pkg::*;
  ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/glyph_coverage_alpha_blend.sv
// glyph_coverage_alpha_blend: rgba canvas with over compositing of glyph coverage pixels
//
//   channel   modport  moves
//   req       sink     one blend, clear or read request per transfer
//   rsp       source   one canvas pixel and written flag per request
//   cfg_*     input    region registers, one write per clock
//
// a blend takes the request, fetches the pixel and scales the coverage, forms the new
// alpha, then for each colour runs the shared multiplier and divide-by-255 steps and an
// 8-step restoring division by the new alpha, then writes the canvas and gives the
// result; a blend onto an empty pixel skips the colour steps and a read skips the blend.
// after reset and on every clear the canvas is swept one word a cycle over all
// CANVAS_WIDTH*CANVAS_HEIGHT words (65536 at the defaults); req is not ready then.
// req is ready only when the block is idle; a result holds until rsp transfers.
`default_nettype none
module glyph_coverage_alpha_blend
  import gcab_pkg::*;
#(
  parameter int CANVAS_WIDTH  = 512,
  parameter int CANVAS_HEIGHT = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  gcab_req_if.sink                   req,
  gcab_rsp_if.source                 rsp,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // region registers
  logic [11:0] region_left;
  logic [11:0] region_top;
  logic [9:0]  region_width;
  logic [7:0]  region_height;

  state_t state, state_next;

  req_t              req_q;
  logic [12:0]       cx, cy;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] sweep;
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_data;
  rsp_t              result;

  logic [23:0] prod;
  logic [16:0] qe;
  logic [16:0] q255;
  logic [7:0]  an;
  logic [7:0]  na;
  logic [16:0] num;
  logic [8:0]  rem;
  logic [7:0]  low;
  logic [7:0]  quo;
  logic [2:0]  cnt;
  logic [1:0]  ch;
  logic [7:0]  mix [3];

  // combinational control and datapath
  logic        mul_en;
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic        wr_en;
  logic        sweeping;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0] wr_data;

  logic        fit_ok;
  logic        in_canvas;
  logic [12:0] cx_calc, cy_calc;
  logic [25:0] lin;
  logic [7:0]  ao;
  logic [7:0]  old_c;
  logic [7:0]  new_c;
  logic [7:0]  na_calc;
  logic [16:0] sum;
  logic [9:0]  trial;
  logic        ge;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      region_left   <= '0;
      region_top    <= '0;
      region_width  <= '0;
      region_height <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REGION_LEFT:   region_left   <= cfg_data[11:0];
        CFG_REGION_TOP:    region_top    <= cfg_data[11:0];
        CFG_REGION_WIDTH:  region_width  <= cfg_data[9:0];
        CFG_REGION_HEIGHT: region_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // placement checks
  always_comb begin
    fit_ok = !((req_q.image_left < region_left) ||
               (13'(req_q.image_left) + 13'(req_q.image_width) >
                13'(region_left) + 13'(region_width)) ||
               (req_q.image_top < region_top) ||
               (13'(req_q.image_top) + 13'(req_q.image_height) >
                13'(region_top) + 13'(region_height)) ||
               (req_q.pixel_col >= req_q.image_width) ||
               (req_q.pixel_row >= req_q.image_height));
    if (req_q.req_type == REQ_READ) begin
      cx_calc = 13'(req_q.pixel_col);
      cy_calc = 13'(req_q.pixel_row);
    end else begin
      cx_calc = 13'(req_q.pixel_col) + 13'(req_q.image_left) - 13'(region_left);
      cy_calc = 13'(req_q.pixel_row) + 13'(req_q.image_top) - 13'(region_top);
    end
    in_canvas = (cx_calc < 13'(CANVAS_WIDTH)) && (cy_calc < 13'(CANVAS_HEIGHT));
    lin = 26'(cy) * 26'(CANVAS_WIDTH) + 26'(cx);
  end

  // blend datapath selections
  always_comb begin
    ao = rd_data[7:0];
    case (ch)
      2'd0:    old_c = rd_data[31:24];
      2'd1:    old_c = rd_data[23:16];
      default: old_c = rd_data[15:8];
    endcase
    case (ch)
      2'd0:    new_c = req_q.packed_color[31:24];
      2'd1:    new_c = req_q.packed_color[23:16];
      default: new_c = req_q.packed_color[15:8];
    endcase
    q255    = div255_fix(prod, qe);
    na_calc = 8'd255 - q255[7:0];
    sum     = num + prod[16:0];
    trial   = {rem, low[7]};
    ge      = (trial >= {2'b00, na});
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:    if (sweep == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:    if (req.valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (req_q.req_type == REQ_CLEAR) begin
          state_next = ST_CLEAR;
        end else if ((req_q.req_type == REQ_BLEND && fit_ok && in_canvas) ||
                     (req_q.req_type == REQ_READ && in_canvas)) begin
          state_next = ST_ADDR;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_ADDR:    state_next = ST_READ;
      ST_READ:    state_next = ST_LOAD;
      ST_LOAD:    state_next = (req_q.req_type == REQ_READ) ? ST_OUT : ST_AN_EST;
      ST_AN_EST:  state_next = ST_AN_DIV;
      ST_AN_DIV:  state_next = (ao == 8'd0) ? ST_WRITE : ST_NA_MUL;
      ST_NA_MUL:  state_next = ST_NA_EST;
      ST_NA_EST:  state_next = ST_NA_DIV;
      ST_NA_DIV:  state_next = (na_calc == 8'd0) ? ST_WRITE : ST_CH_MUL1;
      ST_CH_MUL1: state_next = ST_CH_MUL2;
      ST_CH_MUL2: state_next = ST_CH_EST;
      ST_CH_EST:  state_next = ST_CH_DIV;
      ST_CH_DIV:  state_next = ST_CH_SUM;
      ST_CH_SUM:  state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (cnt == 3'd7) state_next = (ch == 2'd2) ? ST_WRITE : ST_CH_MUL1;
      end
      ST_WRITE:   state_next = ST_OUT;
      ST_CLEAR:   if (sweep == LAST_ADDR) state_next = ST_OUT;
      ST_OUT:     if (rsp.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs and shared unit operands
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    wr_en     = 1'b0;
    sweeping  = 1'b0;
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    case (state)
      ST_INIT, ST_CLEAR: begin
        wr_en    = 1'b1;
        sweeping = 1'b1;
      end
      ST_IDLE: req.ready = 1'b1;
      ST_LOAD: begin
        mul_en = 1'b1;
        mul_a  = {8'd0, 8'd255 - req_q.packed_color[7:0]};
        mul_b  = req_q.coverage;
      end
      ST_NA_MUL: begin
        mul_en = 1'b1;
        mul_a  = {8'd0, 8'd255 - ao};
        mul_b  = 8'd255 - an;
      end
      ST_CH_MUL1: begin
        mul_en = 1'b1;
        mul_a  = {8'd0, old_c};
        mul_b  = ao;
      end
      ST_CH_MUL2: begin
        mul_en = 1'b1;
        mul_a  = prod[15:0];
        mul_b  = 8'd255 - an;
      end
      ST_CH_DIV: begin
        mul_en = 1'b1;
        mul_a  = {8'd0, new_c};
        mul_b  = an;
      end
      ST_WRITE: wr_en = 1'b1;
      ST_OUT:   rsp.valid = 1'b1;
      default: ;
    endcase
    wr_addr  = sweeping ? sweep : addr;
    wr_data  = sweeping ? 32'd0 : {mix[0], mix[1], mix[2], na};
    rsp.data = result;
  end

  // canvas memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
    end else begin
      state <= state_next;
      if (sweeping) sweep <= (sweep == LAST_ADDR) ? '0 : sweep + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    qe <= div255_est(prod);
    if (mul_en) prod <= 24'(mul_a) * 24'(mul_b);
    case (state)
      ST_IDLE: if (req.valid) req_q <= req.data;
      ST_CHECK: begin
        cx     <= cx_calc;
        cy     <= cy_calc;
        result <= '0;
      end
      ST_ADDR: addr <= lin[ADDR_W-1:0];
      ST_LOAD: begin
        if (req_q.req_type == REQ_READ) begin
          result <= '{rd_data[31:24], rd_data[23:16], rd_data[15:8], rd_data[7:0], 1'b0};
        end
      end
      ST_AN_DIV: begin
        an <= q255[7:0];
        if (ao == 8'd0) begin
          na     <= q255[7:0];
          mix[0] <= req_q.packed_color[31:24];
          mix[1] <= req_q.packed_color[23:16];
          mix[2] <= req_q.packed_color[15:8];
        end
      end
      ST_NA_DIV: begin
        na     <= na_calc;
        ch     <= 2'd0;
        mix[0] <= rd_data[31:24];
        mix[1] <= rd_data[23:16];
        mix[2] <= rd_data[15:8];
      end
      ST_CH_DIV: num <= {1'b0, q255[15:0]};
      ST_CH_SUM: begin
        // quotient fits in 8 bits, so the top bits start below the divisor
        rem <= sum[16:8];
        low <= sum[7:0];
        quo <= '0;
        cnt <= '0;
      end
      ST_DIVIDE: begin
        rem <= ge ? 9'(trial - {2'b00, na}) : trial[8:0];
        low <= {low[6:0], 1'b0};
        quo <= {quo[6:0], ge};
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          mix[ch] <= {quo[6:0], ge};
          if (ch != 2'd2) ch <= ch + 2'd1;
        end
      end
      ST_WRITE: result <= '{mix[0], mix[1], mix[2], na, 1'b1};
      default: ;
    endcase
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("request taken while a result is pending");

  a_written_blend: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.pixel_written) |-> (req_q.req_type == REQ_BLEND))
    else $error("written flag on a non-blend request");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < {1'b0, na}))
    else $error("divider remainder out of range");

  a_write_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (state == ST_OUT))
    else $error("canvas write not followed by result");

endmodule
`default_nettype wire
